// ----- rtl/dvru_pkg.sv -----
`timescale 1ns / 1ps

package dvru_pkg;

    // Defaults for the top-level parameters.
    localparam int NODE_COUNT_DEF = 4;
    localparam int INF_COST_DEF   = 999;

    // Fixed field widths of the channels and the register port.
    localparam int FIELD_W    = 10;
    localparam int NODE_W     = 2;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Depth of the command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_LINK_1 = 2'd0;
    localparam logic [1:0] REG_LINK_2 = 2'd1;
    localparam logic [1:0] REG_LINK_3 = 2'd2;

    // Reset values of the link cost registers.
    localparam logic [FIELD_W-1:0] LINK_1_RESET = 10'd1;
    localparam logic [FIELD_W-1:0] LINK_2_RESET = 10'd3;
    localparam logic [FIELD_W-1:0] LINK_3_RESET = 10'd7;

    // Diagonal of the cost table after reset, for nodes 0 to 3.
    localparam logic [FIELD_W-1:0] RESET_DIAG [4] = '{10'd0, 10'd1, 10'd3, 10'd7};

    // Operation codes of an input item.
    localparam logic [1:0] OP_INIT        = 2'd0;
    localparam logic [1:0] OP_ADVERT      = 2'd1;
    localparam logic [1:0] OP_LINK_CHANGE = 2'd2;

    // One input item.
    typedef struct packed {
        logic [NODE_W-1:0]  operation;
        logic [NODE_W-1:0]  neighbor;
        logic [FIELD_W-1:0] adv_cost_0;
        logic [FIELD_W-1:0] adv_cost_1;
        logic [FIELD_W-1:0] adv_cost_2;
        logic [FIELD_W-1:0] adv_cost_3;
        logic [FIELD_W-1:0] link_cost_new;
    } item_t;

    // One result item (one advertisement packet).
    typedef struct packed {
        logic [NODE_W-1:0]  dest_node;
        logic [FIELD_W-1:0] min_cost_0;
        logic [FIELD_W-1:0] min_cost_1;
        logic [FIELD_W-1:0] min_cost_2;
        logic [FIELD_W-1:0] min_cost_3;
        logic               last_packet;
    } result_t;

    // Classified command passed from the front part to the back part.
    typedef enum logic [1:0] {
        CMD_INIT,
        CMD_ADVERT,
        CMD_CHANGE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                   kind;
        logic [NODE_W-1:0]           neighbor;
        logic [3:0][FIELD_W-1:0]     adv_cost;
        logic [FIELD_W-1:0]          link_cost_new;
    } cmd_t;

    // Configured link costs as seen by the back part.
    typedef struct packed {
        logic [FIELD_W-1:0] link_1;
        logic [FIELD_W-1:0] link_2;
        logic [FIELD_W-1:0] link_3;
    } link_cfg_t;

    // Status of the command queue.
    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    // Sequencer states of the back part.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT_WR,
        ST_LINK_RD,
        ST_LINK_WAIT,
        ST_ROW_RD,
        ST_ROW_WR,
        ST_EMIT
    } back_state_t;

    // Internal cost width: wide enough for the infinity value and for the fields.
    function automatic int cost_width(input int inf);
        int w;
        w = $clog2(inf + 1);
        return (w > FIELD_W) ? w : FIELD_W;
    endfunction

endpackage

// ----- rtl/distance_vector_route_update.sv -----
`timescale 1ns / 1ps
// An init item writes every row of the cost table in turn, then emits its packets;
// an advertisement or link change reads the link entry, then reads and rewrites each row in turn.
// The sequencer holds one item at a time, bound by the read-modify-write of each table row through
// the cost memory and by its packets, which wait while the receiver stalls; two items can queue.
// Reset (asynchronous, active low): cost table reads as diagonal 0, 1, 3, 7 and infinity
// elsewhere, minimum costs zero, link cost registers 1, 3 and 7, queue and outputs empty.
module distance_vector_route_update #(
    parameter int NODE_COUNT = dvru_pkg::NODE_COUNT_DEF,
    parameter int INF_COST   = dvru_pkg::INF_COST_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  dvru_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output dvru_pkg::result_t                 result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dvru_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [dvru_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [dvru_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import dvru_pkg::*;

    link_cfg_t     link_cfg_reg;
    link_cfg_t     link_cfg_next;
    logic          cfg_write;
    logic [1:0]    reg_idx;
    logic          q_push;
    logic          q_pop;
    cmd_t          q_cmd;
    cmd_t          q_head;
    queue_status_t q_status;

    // Register port: zero wait states, writes land at the access phase.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        link_cfg_next = link_cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_idx)
                REG_LINK_1: link_cfg_next.link_1 = pwdata[FIELD_W-1:0];
                REG_LINK_2: link_cfg_next.link_2 = pwdata[FIELD_W-1:0];
                REG_LINK_3: link_cfg_next.link_3 = pwdata[FIELD_W-1:0];
                default:    link_cfg_next = link_cfg_reg;
            endcase
        end
    end

    // Read-back of the link cost registers.
    always_comb
    begin
        unique case (reg_idx)
            REG_LINK_1: prdata = CFG_DATA_W'(link_cfg_reg.link_1);
            REG_LINK_2: prdata = CFG_DATA_W'(link_cfg_reg.link_2);
            REG_LINK_3: prdata = CFG_DATA_W'(link_cfg_reg.link_3);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_cfg_reg.link_1 <= LINK_1_RESET;
            link_cfg_reg.link_2 <= LINK_2_RESET;
            link_cfg_reg.link_3 <= LINK_3_RESET;
        end
        else
        begin
            link_cfg_reg <= link_cfg_next;
        end
    end

    // Front part: takes items and classifies them.
    dvru_front #(
        .NODE_COUNT (NODE_COUNT)
    ) u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_status   (q_status),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    // Command queue between the two parts.
    dvru_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .status   (q_status)
    );

    // Back part: table update, re-minimisation and packet emission.
    dvru_back #(
        .NODE_COUNT (NODE_COUNT),
        .INF_COST   (INF_COST)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .link_cfg     (link_cfg_reg),
        .q_status     (q_status),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ----- rtl/dvru_front.sv -----
`timescale 1ns / 1ps

module dvru_front #(
    parameter int NODE_COUNT = dvru_pkg::NODE_COUNT_DEF
) (
    input  logic                    item_valid,
    output logic                    item_stall,
    input  dvru_pkg::item_t         item,
    input  dvru_pkg::queue_status_t q_status,
    output logic                    q_push,
    output dvru_pkg::cmd_t          q_cmd
);
    import dvru_pkg::*;

    logic      keep;
    cmd_kind_t kind;
    logic      nb_ok;

    // A neighbour is usable when it is neither this node nor beyond the last node.
    assign nb_ok = (item.neighbor != '0) && (int'(item.neighbor) < NODE_COUNT);

    // Classify the operation; unused codes and bad neighbours are consumed silently.
    always_comb
    begin
        keep = 1'b0;
        kind = CMD_INIT;
        unique case (item.operation)
            OP_INIT:
            begin
                keep = 1'b1;
                kind = CMD_INIT;
            end
            OP_ADVERT:
            begin
                keep = nb_ok;
                kind = CMD_ADVERT;
            end
            OP_LINK_CHANGE:
            begin
                keep = nb_ok;
                kind = CMD_CHANGE;
            end
            default:
            begin
                keep = 1'b0;
                kind = CMD_INIT;
            end
        endcase
    end

    // Build the command for the queue.
    always_comb
    begin
        q_cmd.kind          = kind;
        q_cmd.neighbor      = item.neighbor;
        q_cmd.adv_cost[0]   = item.adv_cost_0;
        q_cmd.adv_cost[1]   = item.adv_cost_1;
        q_cmd.adv_cost[2]   = item.adv_cost_2;
        q_cmd.adv_cost[3]   = item.adv_cost_3;
        q_cmd.link_cost_new = item.link_cost_new;
    end

    // Items are taken whenever the queue has room, including those that are dropped.
    assign item_stall = q_status.full;
    assign q_push     = item_valid && !q_status.full && keep;

endmodule

// ----- rtl/dvru_queue.sv -----
`timescale 1ns / 1ps

module dvru_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  dvru_pkg::cmd_t          push_cmd,
    input  logic                    pop,
    output dvru_pkg::cmd_t          head,
    output dvru_pkg::queue_status_t status
);
    import dvru_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Status flags from the fill count.
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head         = entry_reg[rd_ptr_reg];

    // Pointer and count updates, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count above depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("push into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("pop from an empty queue");

endmodule

// ----- rtl/dvru_back.sv -----
`timescale 1ns / 1ps

module dvru_back #(
    parameter int NODE_COUNT = dvru_pkg::NODE_COUNT_DEF,
    parameter int INF_COST   = dvru_pkg::INF_COST_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dvru_pkg::link_cfg_t     link_cfg,
    input  dvru_pkg::queue_status_t q_status,
    input  dvru_pkg::cmd_t          q_head,
    output logic                    q_pop,
    output logic                    result_valid,
    input  logic                    result_stall,
    output dvru_pkg::result_t       result
);
    import dvru_pkg::*;

    localparam int CW        = cost_width(INF_COST);
    localparam int IDX_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int PKT_COUNT = (NODE_COUNT - 1 > 3) ? 3 : NODE_COUNT - 1;
    localparam logic [CW-1:0]    INF      = CW'(INF_COST);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);
    localparam logic [1:0]       LAST_PKT = 2'(PKT_COUNT - 1);

    typedef logic [NODE_COUNT-1:0][CW-1:0] row_t;

    // Cost table, one row (destination) per memory word, with a valid bit per row.
    row_t                  mem [NODE_COUNT];
    logic [NODE_COUNT-1:0] row_valid_reg;
    logic [NODE_COUNT-1:0] row_valid_next;
    row_t                  rd_data_reg;
    logic                  rd_valid_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    row_t                  mem_wdata;

    // Sequencer and working registers.
    back_state_t      state_reg;
    back_state_t      state_next;
    cmd_t             cmd_reg;
    cmd_t             cmd_next;
    logic [IDX_W-1:0] d_reg;
    logic [IDX_W-1:0] d_next;
    logic [CW-1:0]    link_reg;
    logic [CW-1:0]    link_next;
    logic             changed_reg;
    logic             changed_next;
    logic [CW-1:0]    best_reg [NODE_COUNT];
    logic [CW-1:0]    best_next [NODE_COUNT];
    logic [1:0]       pkt_reg;
    logic [1:0]       pkt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_reg;
    result_t          out_next;

    // Row arithmetic.
    logic [IDX_W-1:0] nb_idx;
    logic [IDX_W+1:0] d_wide;
    row_t             row_cur;
    row_t             row_upd;
    row_t             row_init;
    logic [CW-1:0]    entry_old;
    logic [CW-1:0]    adv_c;
    logic [CW-1:0]    new_c;
    logic [CW-1:0]    entry_new;
    logic [CW:0]      adv_sum;
    logic [CW+1:0]    shift_sum;
    logic [CW-1:0]    row_min;
    logic [CW-1:0]    diag_init;
    logic             row_changed;
    logic             out_load;
    logic [FIELD_W-1:0] min_f [4];

    function automatic logic [CW-1:0] clamp_cost(input logic [CW:0] v);
        return (v > {1'b0, INF}) ? INF : v[CW-1:0];
    endfunction

    // Row with the given diagonal entry and infinity elsewhere.
    function automatic row_t fill_row(input logic [IDX_W-1:0] d, input logic [CW-1:0] diag);
        row_t r;
        for (int v = 0; v < NODE_COUNT; v++)
        begin
            r[v] = (IDX_W'(v) == d) ? diag : INF;
        end
        return r;
    endfunction

    // Contents of a row that has not been written since reset.
    function automatic row_t reset_row(input logic [IDX_W-1:0] d);
        logic [IDX_W+1:0] dw;
        logic [CW-1:0]    diag;
        dw   = (IDX_W + 2)'(d);
        diag = (dw < 4) ? CW'(RESET_DIAG[dw[1:0]]) : INF;
        return fill_row(d, diag);
    endfunction

    assign nb_idx  = IDX_W'(cmd_reg.neighbor);
    assign d_wide  = (IDX_W + 2)'(d_reg);
    assign row_cur = rd_valid_reg ? rd_data_reg : reset_row(rd_idx_reg);

    // New value of the neighbour's entry in the current row.
    always_comb
    begin
        entry_old = row_cur[nb_idx];
        adv_c     = (d_wide < 4) ? clamp_cost((CW + 1)'(cmd_reg.adv_cost[d_wide[1:0]])) : INF;
        new_c     = clamp_cost((CW + 1)'(cmd_reg.link_cost_new));
        adv_sum   = {1'b0, link_reg} + {1'b0, adv_c};
        shift_sum = {2'b00, entry_old} + {2'b00, new_c} - {2'b00, link_reg};
        if (cmd_reg.kind == CMD_ADVERT)
        begin
            entry_new = clamp_cost(adv_sum);
        end
        else if (shift_sum[CW+1])
        begin
            entry_new = '0;
        end
        else
        begin
            entry_new = clamp_cost(shift_sum[CW:0]);
        end
        row_upd         = row_cur;
        row_upd[nb_idx] = entry_new;
    end

    // Minimum of the updated row.
    always_comb
    begin
        row_min = row_upd[0];
        for (int v = 1; v < NODE_COUNT; v++)
        begin
            if (row_upd[v] < row_min)
            begin
                row_min = row_upd[v];
            end
        end
        row_changed = (row_min != best_reg[d_reg]);
    end

    // Diagonal of the init row from the configured link costs.
    always_comb
    begin
        case (d_wide)
            (IDX_W + 2)'(0): diag_init = '0;
            (IDX_W + 2)'(1): diag_init = clamp_cost((CW + 1)'(link_cfg.link_1));
            (IDX_W + 2)'(2): diag_init = clamp_cost((CW + 1)'(link_cfg.link_2));
            (IDX_W + 2)'(3): diag_init = clamp_cost((CW + 1)'(link_cfg.link_3));
            default:         diag_init = INF;
        endcase
        row_init = fill_row(d_reg, diag_init);
    end

    // The output register may take a new packet when empty or being drained.
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || !result_stall);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = (q_head.kind == CMD_INIT) ? ST_INIT_WR : ST_LINK_RD;
                end
            end
            ST_INIT_WR:
            begin
                if (d_reg == LAST_IDX)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_LINK_RD:   state_next = ST_LINK_WAIT;
            ST_LINK_WAIT: state_next = ST_ROW_RD;
            ST_ROW_RD:    state_next = ST_ROW_WR;
            ST_ROW_WR:
            begin
                if (d_reg != LAST_IDX)
                begin
                    state_next = ST_ROW_RD;
                end
                else if (changed_reg || row_changed)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_load && (pkt_reg == LAST_PKT))
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath controls and register updates for each state.
    always_comb
    begin
        q_pop          = 1'b0;
        cmd_next       = cmd_reg;
        d_next         = d_reg;
        link_next      = link_reg;
        changed_next   = changed_reg;
        pkt_next       = pkt_reg;
        rd_addr        = d_reg;
        mem_we         = 1'b0;
        mem_waddr      = d_reg;
        mem_wdata      = row_upd;
        row_valid_next = row_valid_reg;
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            best_next[i] = best_reg[i];
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop        = 1'b1;
                    cmd_next     = q_head;
                    d_next       = '0;
                    changed_next = 1'b0;
                    pkt_next     = '0;
                end
            end
            ST_INIT_WR:
            begin
                mem_we                = 1'b1;
                mem_wdata             = row_init;
                row_valid_next[d_reg] = 1'b1;
                best_next[d_reg]      = diag_init;
                d_next                = d_reg + 1'b1;
            end
            ST_LINK_RD:
            begin
                rd_addr = nb_idx;
            end
            ST_LINK_WAIT:
            begin
                link_next = row_cur[nb_idx];
            end
            ST_ROW_RD:
            begin
                rd_addr = d_reg;
            end
            ST_ROW_WR:
            begin
                mem_we                = 1'b1;
                mem_wdata             = row_upd;
                row_valid_next[d_reg] = 1'b1;
                best_next[d_reg]      = row_min;
                changed_next          = changed_reg || row_changed;
                d_next                = d_reg + 1'b1;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    pkt_next = pkt_reg + 1'b1;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Minimum-cost fields; nodes beyond the last one read zero.
    for (genvar g = 0; g < 4; g++)
    begin : g_min_field
        if (g < NODE_COUNT)
        begin : g_used
            assign min_f[g] = best_reg[g][FIELD_W-1:0];
        end
        else
        begin : g_unused
            assign min_f[g] = '0;
        end
    end

    // Output register: one packet per transfer, held while stalled.
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        if (out_load)
        begin
            out_next.dest_node   = pkt_reg + 1'b1;
            out_next.min_cost_0  = min_f[0];
            out_next.min_cost_1  = min_f[1];
            out_next.min_cost_2  = min_f[2];
            out_next.min_cost_3  = min_f[3];
            out_next.last_packet = (pkt_reg == LAST_PKT);
            out_valid_next       = 1'b1;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            d_reg         <= '0;
            changed_reg   <= 1'b0;
            pkt_reg       <= '0;
            out_valid_reg <= 1'b0;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                best_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            d_reg         <= d_next;
            changed_reg   <= changed_next;
            pkt_reg       <= pkt_next;
            out_valid_reg <= out_valid_next;
            row_valid_reg <= row_valid_next;
            rd_valid_reg  <= row_valid_reg[rd_addr];
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                best_reg[i] <= best_next[i];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        link_reg   <= link_next;
        out_reg    <= out_next;
        rd_idx_reg <= rd_addr;
    end

    // Cost table memory, registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE))
        else $error("command taken while the sequencer is busy");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside the packet run");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_stall) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled result lost or changed");

    a_link_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROW_WR) |-> (link_reg <= INF))
        else $error("captured link cost above infinity");

endmodule

// ----- tb/tb_distance_vector_route_update.sv -----
`timescale 1ns / 1ps

module tb_distance_vector_route_update;

    import dvru_pkg::*;

    localparam int        NODES        = 4;
    localparam int        INF          = INF_COST_DEF;
    localparam int        CLK_HALF     = 6;
    localparam int        SETTLE_WAIT  = 40;
    localparam int        HOLD_CYCLES  = 400;
    localparam int        LIMIT_CYCLES = 200000;
    localparam int        PHASE_ITEMS  = 20;
    localparam int        MAX_PRINTS   = 100;
    localparam logic[1:0] OP_UNUSED    = 2'd3;

    typedef logic [FIELD_W-1:0] cost_t;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    item_t                 item = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Items waiting to be offered, and advertisement packets still owed by the block.
    item_t   route_items[$];
    result_t pending_packets[$];

    // Predicted routing state of the node.
    cost_t route_cost [NODES][NODES];
    cost_t best_cost  [NODES];
    cost_t link_reg   [3];

    // Pacing controls set by the sequence, read by the driver and the receiver.
    int idle_pct = 10;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    logic item_taken = 1'b0;

    int errors = 0;
    int cycles = 0;
    int items_taken = 0;
    int packets_checked = 0;
    int cfg_writes = 0;
    int init_count = 0;
    int advert_count = 0;
    int change_count = 0;
    int ignored_count = 0;

    distance_vector_route_update i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic cost_t sat_cost(input int v);
        if (v < 0)
            return '0;
        if (v > INF)
            return cost_t'(INF);
        return cost_t'(v);
    endfunction

    // Row minima of the cost table; tells whether the distance vector moved.
    function automatic bit refresh_best();
        bit    moved;
        cost_t m;
        moved = 1'b0;
        for (int d = 0; d < NODES; d++)
        begin
            m = route_cost[d][0];
            for (int v = 1; v < NODES; v++)
                if (route_cost[d][v] < m)
                    m = route_cost[d][v];
            if (m != best_cost[d])
                moved = 1'b1;
            best_cost[d] = m;
        end
        return moved;
    endfunction

    // One advertisement packet to each of the neighbours, in node order.
    function automatic void queue_packets();
        result_t pkt;
        for (int k = 0; k < 3; k++)
        begin
            pkt.dest_node   = NODE_W'(k + 1);
            pkt.min_cost_0  = best_cost[0];
            pkt.min_cost_1  = best_cost[1];
            pkt.min_cost_2  = best_cost[2];
            pkt.min_cost_3  = best_cost[3];
            pkt.last_packet = (k == 2);
            pending_packets.push_back(pkt);
        end
    endfunction

    // Applies one accepted item to the predicted table and queues the packets it causes.
    function automatic void update_routes(input item_t it);
        int    nb;
        cost_t base;
        cost_t shifted;
        cost_t adv [NODES];
        nb = it.neighbor;
        adv[0] = it.adv_cost_0;
        adv[1] = it.adv_cost_1;
        adv[2] = it.adv_cost_2;
        adv[3] = it.adv_cost_3;
        if (it.operation == OP_INIT)
        begin
            init_count++;
            for (int d = 0; d < NODES; d++)
                for (int v = 0; v < NODES; v++)
                    if (d != v)
                        route_cost[d][v] = cost_t'(INF);
                    else if (d == 0)
                        route_cost[d][v] = '0;
                    else
                        route_cost[d][v] = sat_cost(int'(link_reg[d-1]));
            void'(refresh_best());
            queue_packets();
            return;
        end
        if ((it.operation != OP_ADVERT && it.operation != OP_LINK_CHANGE) || nb == 0)
        begin
            ignored_count++;
            return;
        end
        base = route_cost[nb][nb];
        if (it.operation == OP_ADVERT)
        begin
            advert_count++;
            for (int d = 0; d < NODES; d++)
                route_cost[d][nb] = sat_cost(int'(base) + int'(sat_cost(int'(adv[d]))));
        end
        else
        begin
            change_count++;
            shifted = sat_cost(int'(it.link_cost_new));
            for (int d = 0; d < NODES; d++)
                route_cost[d][nb] = sat_cost(int'(route_cost[d][nb]) - int'(base)
                                             + int'(shifted));
        end
        if (refresh_best())
            queue_packets();
    endfunction

    // Compares one packet from the block with the oldest one owed.
    task automatic check_packet(input result_t got);
        result_t want;
        if (pending_packets.size() == 0)
        begin
            report_mismatch("unexpected packet to node", got.dest_node, 0);
            return;
        end
        want = pending_packets.pop_front();
        packets_checked++;
        if (got.dest_node !== want.dest_node)
            report_mismatch("dest_node", got.dest_node, want.dest_node);
        if (got.min_cost_0 !== want.min_cost_0)
            report_mismatch("min_cost_0", got.min_cost_0, want.min_cost_0);
        if (got.min_cost_1 !== want.min_cost_1)
            report_mismatch("min_cost_1", got.min_cost_1, want.min_cost_1);
        if (got.min_cost_2 !== want.min_cost_2)
            report_mismatch("min_cost_2", got.min_cost_2, want.min_cost_2);
        if (got.min_cost_3 !== want.min_cost_3)
            report_mismatch("min_cost_3", got.min_cost_3, want.min_cost_3);
        if (got.last_packet !== want.last_packet)
            report_mismatch("last_packet", got.last_packet, want.last_packet);
    endtask

    // Monitor: outputs are checked before the item of the same edge is predicted.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_taken <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_packet(result);
            if (item_valid && !item_stall)
            begin
                items_taken++;
                update_routes(item);
            end
            item_taken <= item_valid && !item_stall;
        end
    end

    // Input driver: a new item is offered only once the previous transfer has happened.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else if (!item_valid || item_taken)
        begin
            if (route_items.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                item       <= route_items.pop_front();
                item_valid <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else if (hold_seen != hold_seq)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES - 1;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d packets still owed", cycles,
                     pending_packets.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic item_t make_item(input logic [1:0] op, input int nb, input int c0,
                                        input int c1, input int c2, input int c3,
                                        input int link_new);
        item_t it;
        it.operation     = op;
        it.neighbor      = NODE_W'(nb);
        it.adv_cost_0    = cost_t'(c0);
        it.adv_cost_1    = cost_t'(c1);
        it.adv_cost_2    = cost_t'(c2);
        it.adv_cost_3    = cost_t'(c3);
        it.link_cost_new = cost_t'(link_new);
        return it;
    endfunction

    // Costs lean towards small values so that routes compete, with infinity and
    // out-of-range values mixed in.
    function automatic int rand_cost();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return $urandom_range(15);
        if (r < 65)
            return $urandom_range(INF);
        if (r < 78)
            return INF;
        if (r < 86)
            return $urandom_range(1023, INF + 1);
        return $urandom_range(1023);
    endfunction

    function automatic item_t random_route_item();
        int          r;
        logic [1:0]  op;
        int          nb;
        r  = $urandom_range(99);
        nb = $urandom_range(3, 1);
        if (r < 8)
        begin
            op = OP_INIT;
            nb = $urandom_range(3);
        end
        else if (r < 55)
            op = OP_ADVERT;
        else if (r < 85)
            op = OP_LINK_CHANGE;
        else if (r < 92)
        begin
            op = OP_UNUSED;
            nb = $urandom_range(3);
        end
        else
        begin
            op = ($urandom_range(1) != 0) ? OP_ADVERT : OP_LINK_CHANGE;
            nb = 0;
        end
        return make_item(op, nb, rand_cost(), rand_cost(), rand_cost(), rand_cost(),
                         rand_cost());
    endfunction

    function automatic int pick_link();
        int r;
        r = $urandom_range(99);
        if (r < 20)
            return 0;
        if (r < 40)
            return INF;
        if (r < 50)
            return 1023;
        if (r < 80)
            return $urandom_range(20, 1);
        return $urandom_range(1023);
    endfunction

    // Register transfers: setup cycle, then access cycle.
    task automatic write_reg(input logic [1:0] idx, input int value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = CFG_DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        link_reg[idx] = cost_t'(value);
        cfg_writes++;
    endtask

    task automatic check_reg(input logic [1:0] idx);
        logic [CFG_DATA_W-1:0] data;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        data = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (data !== CFG_DATA_W'(link_reg[idx]))
            report_mismatch("link cost register read", data, link_reg[idx]);
    endtask

    task automatic set_links(input int l1, input int l2, input int l3);
        write_reg(REG_LINK_1, l1);
        write_reg(REG_LINK_2, l2);
        write_reg(REG_LINK_3, l3);
        check_reg(REG_LINK_1);
        check_reg(REG_LINK_2);
        check_reg(REG_LINK_3);
    endtask

    // Waits until every item is taken and every packet has come, then lets the
    // block finish any update that sends nothing.
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (route_items.size() != 0 || item_valid || pending_packets.size() != 0);
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    // Phase controls change just after a rising edge, away from the driving edge.
    task automatic start_phase(input int pct, input bit hold);
        @(posedge clk);
        idle_pct = pct;
        if (hold)
            hold_seq++;
    endtask

    task automatic queue_random_phase();
        route_items.push_back(make_item(OP_INIT, $urandom_range(3), 0, 0, 0, 0, 0));
        for (int n = 1; n < PHASE_ITEMS; n++)
            route_items.push_back(random_route_item());
    endtask

    // Test sequence.
    initial
    begin
        rst_n = 1'b0;
        for (int d = 0; d < NODES; d++)
        begin
            best_cost[d] = '0;
            for (int v = 0; v < NODES; v++)
                route_cost[d][v] = (d == v) ? RESET_DIAG[d] : cost_t'(INF);
        end
        link_reg[0] = LINK_1_RESET;
        link_reg[1] = LINK_2_RESET;
        link_reg[2] = LINK_3_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Registers read back their reset values.
        check_reg(REG_LINK_1);
        check_reg(REG_LINK_2);
        check_reg(REG_LINK_3);

        // Directed: advertisement on the reset table, clamping, no-change updates,
        // shifts below zero and above infinity, and the items that are ignored.
        start_phase(10, 1'b0);
        route_items.push_back(make_item(OP_ADVERT, 1, 0, 0, 0, 0, 0));
        route_items.push_back(make_item(OP_INIT, 0, 0, 0, 0, 0, 0));
        route_items.push_back(make_item(OP_ADVERT, 1, 1023, 1023, 1023, 1023, 1023));
        route_items.push_back(make_item(OP_ADVERT, 2, 0, 0, 0, 0, 0));
        route_items.push_back(make_item(OP_ADVERT, 2, 0, 0, 0, 0, 0));
        route_items.push_back(make_item(OP_ADVERT, 3, INF, INF, INF, INF, 0));
        route_items.push_back(make_item(OP_LINK_CHANGE, 1, 5, 5, 5, 5, 0));
        route_items.push_back(make_item(OP_LINK_CHANGE, 2, 0, 0, 0, 0, 1023));
        route_items.push_back(make_item(OP_LINK_CHANGE, 2, 0, 0, 0, 0, INF));
        route_items.push_back(make_item(OP_UNUSED, 1, 0, 0, 0, 0, 0));
        route_items.push_back(make_item(OP_ADVERT, 0, 0, 0, 0, 0, 0));
        route_items.push_back(make_item(OP_LINK_CHANGE, 0, 0, 0, 0, 0, 0));
        route_items.push_back(make_item(OP_LINK_CHANGE, 3, 0, 0, 0, 0, 0));
        route_items.push_back(make_item(OP_INIT, 3, 1023, 1023, 1023, 1023, 1023));
        wait_quiet();

        // Link costs at their extremes.
        set_links(INF, 0, 1023);
        start_phase(10, 1'b0);
        route_items.push_back(make_item(OP_INIT, 1, 0, 0, 0, 0, 0));
        route_items.push_back(make_item(OP_ADVERT, 2, 5, 1023, 0, INF, 0));
        route_items.push_back(make_item(OP_LINK_CHANGE, 1, 0, 0, 0, 0, 1));
        route_items.push_back(make_item(OP_ADVERT, 3, 0, 1, 2, 3, 0));
        wait_quiet();

        set_links(0, 0, 0);
        start_phase(10, 1'b0);
        route_items.push_back(make_item(OP_INIT, 2, 0, 0, 0, 0, 0));
        route_items.push_back(make_item(OP_LINK_CHANGE, 3, 0, 0, 0, 0, INF));
        route_items.push_back(make_item(OP_ADVERT, 1, 1023, 1023, 1023, 1023, 0));
        wait_quiet();

        // Random phases: normal pacing, a stretch without idling, a long receiver
        // hold-off while items keep coming, then normal pacing again.
        for (int ph = 0; ph < 4; ph++)
        begin
            set_links(pick_link(), pick_link(), pick_link());
            start_phase((ph == 1) ? 0 : 10, ph == 2);
            queue_random_phase();
            wait_quiet();
        end

        if (pending_packets.size() != 0)
            report_mismatch("packets never sent", 0, pending_packets.size());

        $display("Run covered %0d items (%0d init, %0d advertisement, %0d link change, %0d ignored)",
                 items_taken, init_count, advert_count, change_count, ignored_count);
        $display("and %0d packets checked over %0d link cost register writes",
                 packets_checked, cfg_writes);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
